// File: sv/mod_matrix_power_path_count_defines.svh
// Assertion macros shared by the checker of the walk counter.
`ifndef MOD_MATRIX_POWER_PATH_COUNT_DEFINES_SVH
`define MOD_MATRIX_POWER_PATH_COUNT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MMPC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MMPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/mmpc_pkg.sv
// Package of constants, types and the transition matrix of the walk counter.
package mmpc_pkg;

	localparam int ExpBits  = 31;
	localparam int DataW    = 30;
	localparam int Dim      = 6;
	localparam int IdxW     = 3;
	localparam int BankW    = 2;
	localparam int NumBanks = 3;
	localparam int AddrW    = BankW + 2 * IdxW;
	localparam int MemDepth = NumBanks << (2 * IdxW);
	localparam int ProdW    = 2 * DataW;
	localparam int MuW      = DataW + 1;
	localparam int RemW     = 32;

	// Barrett reduction shifts for a modulus between 2^29 and 2^30.
	localparam int BarShiftIn  = DataW - 1;
	localparam int BarShiftOut = DataW + 1;

	localparam logic [DataW-1:0] PrimeMod  = 30'd1000000007;
	localparam logic [RemW-1:0]  PrimeMod2 = 32'd2000000014;
	localparam logic [MuW-1:0]   BarrettMu = MuW'((64'd1 << ProdW) / 64'd1000000007);

	localparam logic [IdxW-1:0] IdxLast = IdxW'(Dim - 1);
	localparam logic [IdxW-1:0] IdxZero = IdxW'(0);

	// Banks that hold the accumulated power, the running square and the spare.
	localparam logic [BankW-1:0] InitBankA = 2'd0;
	localparam logic [BankW-1:0] InitBankS = 2'd1;
	localparam logic [BankW-1:0] InitBankF = 2'd2;

	// Transition matrix, one row per entry, bit c holds column c.
	localparam logic [Dim-1:0] TransRows [Dim] = '{
		6'b000111,
		6'b000001,
		6'b000010,
		6'b111111,
		6'b001000,
		6'b010000
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_NEXT,
		ST_MUL,
		ST_DRAIN,
		ST_SUM,
		ST_SUM_DRAIN,
		ST_OUT
	} seq_state_t;

	typedef enum logic {
		OP_ACC,
		OP_SQR
	} mat_op_t;

	typedef struct packed {
		logic             last;
		logic             to_out;
		logic [AddrW-1:0] waddr;
	} mm_tag_t;

	typedef struct packed {
		logic             vld;
		logic [DataW-1:0] a;
		logic [DataW-1:0] b;
		mm_tag_t          tag;
	} mm_in_t;

	typedef struct packed {
		logic             vld;
		logic [DataW-1:0] res;
		mm_tag_t          tag;
	} mm_out_t;

	typedef struct packed {
		logic [AddrW-1:0] raddr0;
		logic [AddrW-1:0] raddr1;
		logic             we;
		logic [AddrW-1:0] waddr;
		logic [DataW-1:0] wdata;
	} ram_req_t;

endpackage

// File: sv/mmpc_stream_if.sv
// Stream interfaces for the exponent word and the walk count word.
interface mmpc_exp_if import mmpc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [ExpBits-1:0] exponent;

	modport source (output valid, output exponent, input ready);
	modport sink (input valid, input exponent, output ready);
endinterface

interface mmpc_cnt_if import mmpc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [DataW-1:0] walk_count;

	modport source (output valid, output walk_count, input ready);
	modport sink (input valid, input walk_count, output ready);
endinterface

// File: sv/mmpc_bank_ram.sv
// Banked matrix store with two registered read ports and one write port.
module mmpc_bank_ram import mmpc_pkg::*; (
	input  logic             clk,
	input  ram_req_t         req,
	output logic [DataW-1:0] rdata0,
	output logic [DataW-1:0] rdata1
);

	logic [DataW-1:0] mem_q [MemDepth];

	// Write port.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
	end

	// Registered read ports.
	always_ff @(posedge clk) begin
		rdata0 <= mem_q[req.raddr0];
		rdata1 <= mem_q[req.raddr1];
	end

endmodule

// File: sv/mmpc_mulmod.sv
// Pipelined modular multiplier: product, Barrett estimate, correction.
module mmpc_mulmod import mmpc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  mm_in_t  op,
	output mm_out_t res,
	output logic    busy
);

	logic [ProdW-1:0]     prod_s1;
	logic                 vld_s1;
	mm_tag_t              tag_s1;

	logic [MuW-1:0]       qhat_s2;
	logic [RemW-1:0]      plo_s2;
	logic                 vld_s2;
	mm_tag_t              tag_s2;

	logic [RemW-1:0]      qp_s3;
	logic [RemW-1:0]      plo_s3;
	logic                 vld_s3;
	mm_tag_t              tag_s3;

	logic [DataW-1:0]     res_s4;
	logic                 vld_s4;
	mm_tag_t              tag_s4;

	logic [2*MuW-1:0]     est_full;
	logic [MuW+DataW-1:0] qp_full;
	logic [RemW-1:0]      rem_raw;
	logic [RemW-1:0]      rem_fix;

	// Quotient estimate from the top bits of the product.
	assign est_full = (2 * MuW)'(prod_s1[ProdW-1:BarShiftIn]) * (2 * MuW)'(BarrettMu);

	// Estimated quotient times the modulus, low bits only.
	assign qp_full = (MuW + DataW)'(qhat_s2) * (MuW + DataW)'(PrimeMod);

	// The estimate is at most two short, so the remainder is below three moduli.
	always_comb begin
		rem_raw = plo_s3 - qp_s3;
		if (rem_raw >= PrimeMod2) begin
			rem_fix = rem_raw - PrimeMod2;
		end else if (rem_raw >= RemW'(PrimeMod)) begin
			rem_fix = rem_raw - RemW'(PrimeMod);
		end else begin
			rem_fix = rem_raw;
		end
	end

	// Valid flags travel alongside the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= op.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// Data stages.
	always_ff @(posedge clk) begin
		prod_s1 <= ProdW'(op.a) * ProdW'(op.b);
		tag_s1  <= op.tag;
		qhat_s2 <= est_full[2*MuW-1:BarShiftOut];
		plo_s2  <= prod_s1[RemW-1:0];
		tag_s2  <= tag_s1;
		qp_s3   <= qp_full[RemW-1:0];
		plo_s3  <= plo_s2;
		tag_s3  <= tag_s2;
		res_s4  <= rem_fix[DataW-1:0];
		tag_s4  <= tag_s3;
	end

	assign res.vld = vld_s4;
	assign res.res = res_s4;
	assign res.tag = tag_s4;
	assign busy    = vld_s1 | vld_s2 | vld_s3 | vld_s4;

endmodule

// File: sv/mmpc_seq.sv
// Sequencer: loads the start matrices, runs square-and-multiply, sums a column.
module mmpc_seq import mmpc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [ExpBits-1:0] exponent,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [DataW-1:0]   walk_count,
	output ram_req_t           ram_req,
	input  logic [DataW-1:0]   rdata0,
	input  logic [DataW-1:0]   rdata1,
	output mm_in_t             mm_op,
	input  mm_out_t            mm_res,
	input  logic               mm_busy
);

	seq_state_t         state_q;
	seq_state_t         state_d;
	logic [ExpBits-1:0] exp_q;
	logic               a_done_q;
	mat_op_t            op_q;
	logic [BankW-1:0]   a_bank_q;
	logic [BankW-1:0]   s_bank_q;
	logic [BankW-1:0]   f_bank_q;
	logic [IdxW-1:0]    r_q;
	logic [IdxW-1:0]    c_q;
	logic [IdxW-1:0]    k_q;
	logic               init_sel_q;
	logic               rd_vld_s1;
	mm_tag_t            rd_tag_s1;
	logic               rd_sum_s1;
	logic [DataW-1:0]   acc_q;
	logic [DataW-1:0]   sum_q;
	logic               out_valid_q;
	logic [DataW-1:0]   out_data_q;

	logic               r_last;
	logic               c_last;
	logic               k_last;
	logic               busy;
	logic               out_free;
	logic               issue;
	logic               issue_sum;
	mm_tag_t            issue_tag;
	logic [DataW:0]     acc_sum;
	logic [DataW-1:0]   acc_red;
	logic [BankW-1:0]   x_bank;

	assign r_last   = (r_q == IdxLast);
	assign c_last   = (c_q == IdxLast);
	assign k_last   = (k_q == IdxLast);
	assign busy     = rd_vld_s1 | mm_busy;
	assign out_free = !out_valid_q || out_ready;
	assign x_bank   = (op_q == OP_ACC) ? a_bank_q : s_bank_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_INIT;
				end
			end
			ST_INIT: begin
				if (init_sel_q && r_last && c_last) begin
					state_d = ST_NEXT;
				end
			end
			ST_NEXT: begin
				if (exp_q == '0) begin
					state_d = ST_SUM;
				end else if ((exp_q[0] && !a_done_q) || ((exp_q >> 1) != '0)) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				if (r_last && c_last && k_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!busy) begin
					state_d = ST_NEXT;
				end
			end
			ST_SUM: begin
				if (r_last) begin
					state_d = ST_SUM_DRAIN;
				end
			end
			ST_SUM_DRAIN: begin
				if (!busy) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Running sum of one entry, reduced after each term.
	always_comb begin
		acc_sum = {1'b0, acc_q} + {1'b0, mm_res.res};
		if (acc_sum >= {1'b0, PrimeMod}) begin
			acc_red = DataW'(acc_sum - {1'b0, PrimeMod});
		end else begin
			acc_red = acc_sum[DataW-1:0];
		end
	end

	// Memory requests and operand issue for the current state.
	always_comb begin
		issue            = 1'b0;
		issue_sum        = 1'b0;
		issue_tag.last   = k_last;
		issue_tag.to_out = 1'b0;
		issue_tag.waddr  = {f_bank_q, r_q, c_q};
		ram_req.raddr0   = {x_bank, r_q, k_q};
		ram_req.raddr1   = {s_bank_q, k_q, c_q};
		ram_req.we       = mm_res.vld && mm_res.tag.last && !mm_res.tag.to_out;
		ram_req.waddr    = mm_res.tag.waddr;
		ram_req.wdata    = acc_red;
		case (state_q)
			ST_INIT: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = {init_sel_q ? s_bank_q : a_bank_q, r_q, c_q};
				if (init_sel_q) begin
					ram_req.wdata = DataW'(TransRows[r_q][c_q]);
				end else begin
					ram_req.wdata = DataW'(r_q == c_q);
				end
			end
			ST_MUL: begin
				issue = 1'b1;
			end
			ST_SUM: begin
				issue            = 1'b1;
				issue_sum        = 1'b1;
				issue_tag.last   = r_last;
				issue_tag.to_out = 1'b1;
				ram_req.raddr0   = {a_bank_q, r_q, IdxZero};
			end
			default: begin
				issue = 1'b0;
			end
		endcase
	end

	// Operands reach the multiplier in the cycle after the read request.
	assign mm_op.vld = rd_vld_s1;
	assign mm_op.a   = rdata0;
	assign mm_op.b   = rd_sum_s1 ? DataW'(1) : rdata1;
	assign mm_op.tag = rd_tag_s1;

	// Sequencer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			exp_q      <= '0;
			a_done_q   <= 1'b0;
			op_q       <= OP_ACC;
			a_bank_q   <= InitBankA;
			s_bank_q   <= InitBankS;
			f_bank_q   <= InitBankF;
			r_q        <= '0;
			c_q        <= '0;
			k_q        <= '0;
			init_sel_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						exp_q      <= exponent;
						a_done_q   <= 1'b0;
						a_bank_q   <= InitBankA;
						s_bank_q   <= InitBankS;
						f_bank_q   <= InitBankF;
						r_q        <= '0;
						c_q        <= '0;
						k_q        <= '0;
						init_sel_q <= 1'b0;
					end
				end
				ST_INIT: begin
					c_q <= c_last ? '0 : c_q + 1'b1;
					if (c_last) begin
						r_q <= r_last ? '0 : r_q + 1'b1;
						if (r_last) begin
							init_sel_q <= 1'b1;
						end
					end
				end
				ST_NEXT: begin
					if (exp_q[0] && !a_done_q) begin
						op_q <= OP_ACC;
					end else begin
						op_q <= OP_SQR;
						// Top bit reached: the last square is never used.
						if ((exp_q >> 1) == '0) begin
							exp_q    <= exp_q >> 1;
							a_done_q <= 1'b0;
						end
					end
				end
				ST_MUL: begin
					k_q <= k_last ? '0 : k_q + 1'b1;
					if (k_last) begin
						c_q <= c_last ? '0 : c_q + 1'b1;
						if (c_last) begin
							r_q <= r_last ? '0 : r_q + 1'b1;
						end
					end
				end
				ST_DRAIN: begin
					if (!busy) begin
						f_bank_q <= x_bank;
						if (op_q == OP_ACC) begin
							a_bank_q <= f_bank_q;
							a_done_q <= 1'b1;
						end else begin
							s_bank_q <= f_bank_q;
							exp_q    <= exp_q >> 1;
							a_done_q <= 1'b0;
						end
					end
				end
				ST_SUM: begin
					r_q <= r_last ? '0 : r_q + 1'b1;
				end
				default: begin
					r_q <= r_q;
				end
			endcase
		end
	end

	// Read-stage tracking, entry accumulator and result word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1   <= 1'b0;
			rd_sum_s1   <= 1'b0;
			rd_tag_s1   <= '0;
			acc_q       <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			rd_vld_s1 <= issue;
			rd_sum_s1 <= issue_sum;
			rd_tag_s1 <= issue_tag;
			if (mm_res.vld) begin
				if (mm_res.tag.last) begin
					acc_q <= '0;
					if (mm_res.tag.to_out) begin
						sum_q <= acc_red;
					end
				end else begin
					acc_q <= acc_red;
				end
			end
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
				out_data_q  <= sum_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign walk_count = out_data_q;

endmodule

// File: sv/mod_matrix_power_path_count.sv
// Top level of the walk counter: raises a fixed 6x6 matrix to a power modulo a prime.
//
// The req channel takes one word, a 31-bit exponent n. The rsp channel returns one
// word, walk_count, the sum of the first column of the matrix power modulo
// 1000000007. Both channels move a word when valid and ready are high together.
// The block holds one exponent at a time: req.ready is high only while it is idle.
// Each word first loads the identity and the transition matrix into the store.
// Every 6x6 modular product then issues its 216 terms to the single
// multiply-reduce pipeline and waits for the pipeline to drain. With p the number
// of set bits of n and m the position of its top bit, a word needs p + m products
// for n > 0 and none for n = 0. The one multiply-reduce unit and the single write
// port of the store set the pace of this work.
// A finished word waits in the output register; a new exponent is accepted while
// it waits, and the block holds its next result until rsp.ready frees that register.
// Reset clears all control state and the output valid; the store needs no clearing.
module mod_matrix_power_path_count import mmpc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	mmpc_exp_if.sink   req,
	mmpc_cnt_if.source rsp
);

	ram_req_t         ram_req;
	logic [DataW-1:0] rdata0;
	logic [DataW-1:0] rdata1;
	mm_in_t           mm_op;
	mm_out_t          mm_res;
	logic             mm_busy;

	// Control sequencer and output register.
	mmpc_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (req.valid),
		.in_ready   (req.ready),
		.exponent   (req.exponent),
		.out_valid  (rsp.valid),
		.out_ready  (rsp.ready),
		.walk_count (rsp.walk_count),
		.ram_req    (ram_req),
		.rdata0     (rdata0),
		.rdata1     (rdata1),
		.mm_op      (mm_op),
		.mm_res     (mm_res),
		.mm_busy    (mm_busy)
	);

	// Three matrix banks: power, square and spare.
	mmpc_bank_ram u_ram (
		.clk    (clk),
		.req    (ram_req),
		.rdata0 (rdata0),
		.rdata1 (rdata1)
	);

	// Shared multiply-reduce unit.
	mmpc_mulmod u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (mm_op),
		.res    (mm_res),
		.busy   (mm_busy)
	);

endmodule

// File: sv/mmpc_checker.sv
// Port checker for the walk counter and its bind to the top level.
`include "mod_matrix_power_path_count_defines.svh"

module mmpc_checker import mmpc_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_ready,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input logic [DataW-1:0] walk_count
);

	// A stalled result stays offered and unchanged.
	`MMPC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "rsp valid dropped")
	`MMPC_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(walk_count), "rsp word changed")

	// Every result is fully reduced.
	`MMPC_ASSERT_NOW(a_rsp_range, rsp_valid, walk_count < PrimeMod, "walk count not reduced")

	// The block is busy in the cycle after it takes an exponent.
	`MMPC_ASSERT_NEXT(a_busy_after_take, req_valid && req_ready, !req_ready, "ready after take")

endmodule

bind mod_matrix_power_path_count mmpc_checker u_mmpc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.walk_count (rsp.walk_count)
);
